// ===== sv/ibs_pkg.sv =====
// Package for the indexed block search: default sizes, configuration register
// indexes, operation codes and the controller state type.
// No dependencies; the top-level module imports it, the RAM does not.
package ibs_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int KEY_WIDTH_DEF    = 32;

  // Widths of the configuration registers and of the configuration port.
  localparam int ELEM_CNT_W = 11;
  localparam int BLK_CNT_W  = 7;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT   = 2'd1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV1_INIT,
    S_DIV1_RUN,
    S_DIV2_INIT,
    S_DIV2_RUN,
    S_LOAD_UPD,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_FETCH,
    S_SCAN
  } ibs_state_t;

endpackage

// ===== sv/ibs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; used for the key table and the block index.
module ibs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/indexed_block_search.sv =====
// Indexed block search. A load word is taken in its accept cycle; one that lands in a block
// already in the index holds busy through S_LOAD_UPD to update that block's maximum. A search
// holds busy through the index probes (S_SRCH_CHK then S_SRCH_CMP each), S_FETCH for the block
// start, then S_SCAN over its keys, unless the key is above every block maximum; done follows
// in the next cycle. A register write holds busy for the two divisions. Reset is synchronous:
// counters clear, n = b = 1, tables stay undefined. The receiver cannot stall.
module indexed_block_search import ibs_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int KEY_WIDTH    = KEY_WIDTH_DEF,
  localparam int AW = $clog2(MAX_ELEMENTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  // Command channel.
  input  logic                  start,
  output logic                  busy,
  input  logic                  op,
  input  logic [KEY_WIDTH-1:0]  value,
  input  logic                  first,
  // Result channel.
  output logic                  done,
  output logic                  found,
  output logic [AW-1:0]         position,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Counter widths: NW holds 0..MAX_ELEMENTS, BW holds 0..MAX_BLOCKS.
  localparam int NW  = $clog2(MAX_ELEMENTS + 1);
  localparam int BW  = $clog2(MAX_BLOCKS + 1);
  localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW  = (NW > BW) ? NW : BW;
  // The divider must hold n + b - 1.
  localparam int DW  = $clog2(MAX_ELEMENTS + MAX_BLOCKS);
  localparam int DCW = $clog2(DW + 1);
  localparam int XW  = KEY_WIDTH + AW;

  ibs_state_t state, state_next;

  // Configuration, already clamped to the legal ranges, and the derived block size.
  logic [NW-1:0] n_eff, n_eff_next;
  logic [BW-1:0] b_eff, b_eff_next;
  logic [NW-1:0] s_len, s_len_next;

  // Load position, split into block number and offset within the block, so that
  // no division is needed per load. They are recomputed after every register write.
  logic [NW-1:0] ld_ptr, ld_ptr_next;
  logic [NW-1:0] ld_blk, ld_blk_next;
  logic [NW-1:0] ld_off, ld_off_next;
  logic [BW-1:0] bf, bf_next;

  // Search working registers.
  logic [KEY_WIDTH-1:0] key_q, key_q_next;
  logic [IW-1:0]        idx_q, idx_q_next;
  logic [BW-1:0]        srch_lo, srch_lo_next;
  logic [BW:0]          srch_hi, srch_hi_next;   // two's complement, may reach -1
  logic [NW-1:0]        scan_addr, scan_addr_next;
  logic [NW-1:0]        scan_end, scan_end_next;
  logic                 chk_v, chk_v_next;
  logic [AW-1:0]        chk_addr, chk_addr_next;

  // Restoring divider, one quotient bit per cycle.
  logic [DW-1:0]  div_a, div_a_next;
  logic [DW-1:0]  div_r, div_r_next;
  logic [DW-1:0]  div_d, div_d_next;
  logic [DCW-1:0] div_cnt, div_cnt_next;
  logic [DW:0]    div_sh, div_sub;
  logic           div_ge;
  logic [DW-1:0]  div_r_step, div_a_step;

  logic          done_next, found_next;
  logic [AW-1:0] position_next;

  // Memory ports.
  logic                 key_we;
  logic [AW-1:0]        key_waddr, key_raddr;
  logic [KEY_WIDTH-1:0] key_wdata, key_rdata;
  logic                 idx_we;
  logic [IW-1:0]        idx_waddr, idx_raddr;
  logic [XW-1:0]        idx_wdata, idx_rdata;

  // Combinational helpers.
  logic [NW-1:0]        p_eff, blk_eff, off_eff;
  logic [BW-1:0]        bf_eff;
  logic [BW:0]          mid_sum;
  logic [BW-1:0]        mid;
  logic                 lo_le_hi;
  logic [KEY_WIDTH-1:0] rd_max;
  logic [AW-1:0]        rd_start;
  logic [NW:0]          end_sum, end_a;
  logic [NW-1:0]        end_b;
  logic [ELEM_CNT_W-1:0] cfg_n;
  logic [BLK_CNT_W-1:0]  cfg_b;

  // Key table: one entry per table position.
  ibs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // Block index: each entry holds the block maximum above the block start position.
  ibs_ram #(
    .WIDTH (XW),
    .DEPTH (MAX_BLOCKS)
  ) u_idx_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .raddr (idx_raddr),
    .rdata (idx_rdata)
  );

  assign busy      = (state != S_IDLE);
  // A command in the same cycle wins; the register write is then taken later.
  assign cfg_ready = (state == S_IDLE) && !start;

  // One divider step.
  assign div_sh     = {div_r, div_a[DW-1]};
  assign div_sub    = div_sh - {1'b0, div_d};
  assign div_ge     = (div_sh >= {1'b0, div_d});
  assign div_r_step = div_ge ? div_sub[DW-1:0] : div_sh[DW-1:0];
  assign div_a_step = {div_a[DW-2:0], div_ge};

  // A load word with first set restarts the table before it is stored.
  assign p_eff   = first ? '0 : ld_ptr;
  assign blk_eff = first ? '0 : ld_blk;
  assign off_eff = first ? '0 : ld_off;
  assign bf_eff  = first ? '0 : bf;

  // Binary search over the filled index entries, bounds inclusive as in the
  // classic formulation; the probe is only taken while low <= high, both non-negative.
  assign lo_le_hi = !srch_hi[BW] && ({1'b0, srch_lo} <= srch_hi);
  assign mid_sum  = {1'b0, srch_lo} + srch_hi;
  assign mid      = mid_sum[BW:1];

  assign rd_max   = idx_rdata[XW-1:AW];
  assign rd_start = idx_rdata[AW-1:0];

  // Block end: min(start + s, n, load pointer).
  assign end_sum = (NW+1)'(rd_start) + (NW+1)'(s_len);
  assign end_a   = (end_sum > {1'b0, n_eff}) ? {1'b0, n_eff} : end_sum;
  assign end_b   = (end_a > {1'b0, ld_ptr}) ? ld_ptr : end_a[NW-1:0];

  assign cfg_n = cfg_data[ELEM_CNT_W-1:0];
  assign cfg_b = cfg_data[BLK_CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      n_eff   <= NW'(1);
      b_eff   <= BW'(1);
      s_len   <= NW'(1);
      ld_ptr  <= '0;
      ld_blk  <= '0;
      ld_off  <= '0;
      bf      <= '0;
      chk_v   <= 1'b0;
      div_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      n_eff   <= n_eff_next;
      b_eff   <= b_eff_next;
      s_len   <= s_len_next;
      ld_ptr  <= ld_ptr_next;
      ld_blk  <= ld_blk_next;
      ld_off  <= ld_off_next;
      bf      <= bf_next;
      chk_v   <= chk_v_next;
      div_cnt <= div_cnt_next;
      done    <= done_next;
    end
    key_q     <= key_q_next;
    idx_q     <= idx_q_next;
    srch_lo   <= srch_lo_next;
    srch_hi   <= srch_hi_next;
    scan_addr <= scan_addr_next;
    scan_end  <= scan_end_next;
    chk_addr  <= chk_addr_next;
    div_a     <= div_a_next;
    div_r     <= div_r_next;
    div_d     <= div_d_next;
    found     <= found_next;
    position  <= position_next;
  end

  always_comb begin
    state_next     = state;
    n_eff_next     = n_eff;
    b_eff_next     = b_eff;
    s_len_next     = s_len;
    ld_ptr_next    = ld_ptr;
    ld_blk_next    = ld_blk;
    ld_off_next    = ld_off;
    bf_next        = bf;
    key_q_next     = key_q;
    idx_q_next     = idx_q;
    srch_lo_next   = srch_lo;
    srch_hi_next   = srch_hi;
    scan_addr_next = scan_addr;
    scan_end_next  = scan_end;
    chk_v_next     = chk_v;
    chk_addr_next  = chk_addr;
    div_a_next     = div_a;
    div_r_next     = div_r;
    div_d_next     = div_d;
    div_cnt_next   = div_cnt;
    done_next      = 1'b0;
    found_next     = found;
    position_next  = position;

    key_we    = 1'b0;
    key_waddr = p_eff[AW-1:0];
    key_wdata = value;
    key_raddr = scan_addr[AW-1:0];
    idx_we    = 1'b0;
    idx_waddr = IW'(blk_eff);
    idx_wdata = {value, p_eff[AW-1:0]};
    idx_raddr = IW'(blk_eff);

    case (state)
      S_IDLE: begin
        if (start) begin
          key_q_next = value;
          if (op == OP_LOAD) begin
            // Restart takes effect even when the word itself falls past the table.
            ld_ptr_next = p_eff;
            ld_blk_next = blk_eff;
            ld_off_next = off_eff;
            bf_next     = bf_eff;
            if (p_eff < n_eff) begin
              key_we      = 1'b1;
              ld_ptr_next = p_eff + NW'(1);
              if (off_eff + NW'(1) == s_len) begin
                ld_off_next = '0;
                ld_blk_next = blk_eff + NW'(1);
              end else begin
                ld_off_next = off_eff + NW'(1);
              end
              if (CW'(blk_eff) >= CW'(bf_eff)) begin
                // First key of a fresh block sets its start and maximum.
                idx_we  = 1'b1;
                bf_next = BW'(blk_eff + NW'(1));
              end else begin
                // Read the block entry; the maximum is updated next cycle.
                idx_q_next = IW'(blk_eff);
                state_next = S_LOAD_UPD;
              end
            end
          end else begin
            srch_lo_next = '0;
            srch_hi_next = {1'b0, bf} - (BW+1)'(1);
            state_next   = S_SRCH_CHK;
          end
        end else if (cfg_valid) begin
          case (cfg_index)
            REG_ELEMENT_COUNT: begin
              if (cfg_n == '0) begin
                n_eff_next = NW'(1);
              end else if (32'(cfg_n) > 32'(MAX_ELEMENTS)) begin
                n_eff_next = NW'(MAX_ELEMENTS);
              end else begin
                n_eff_next = NW'(cfg_n);
              end
            end
            REG_BLOCK_COUNT: begin
              if (cfg_b == '0) begin
                b_eff_next = BW'(1);
              end else if (32'(cfg_b) > 32'(MAX_BLOCKS)) begin
                b_eff_next = BW'(MAX_BLOCKS);
              end else begin
                b_eff_next = BW'(cfg_b);
              end
            end
            default: begin
            end
          endcase
          state_next = S_DIV1_INIT;
        end
      end

      S_DIV1_INIT: begin
        // s = ceil(n / b) = (n + b - 1) / b.
        div_a_next   = DW'(n_eff) + DW'(b_eff) - DW'(1);
        div_d_next   = DW'(b_eff);
        div_r_next   = '0;
        div_cnt_next = DCW'(DW);
        state_next   = S_DIV1_RUN;
      end

      S_DIV1_RUN: begin
        div_a_next   = div_a_step;
        div_r_next   = div_r_step;
        div_cnt_next = div_cnt - DCW'(1);
        if (div_cnt == DCW'(1)) begin
          s_len_next = div_a_step[NW-1:0];
          state_next = S_DIV2_INIT;
        end
      end

      S_DIV2_INIT: begin
        // Block number and offset of the load pointer under the new block size.
        div_a_next   = DW'(ld_ptr);
        div_d_next   = DW'(s_len);
        div_r_next   = '0;
        div_cnt_next = DCW'(DW);
        state_next   = S_DIV2_RUN;
      end

      S_DIV2_RUN: begin
        div_a_next   = div_a_step;
        div_r_next   = div_r_step;
        div_cnt_next = div_cnt - DCW'(1);
        if (div_cnt == DCW'(1)) begin
          ld_blk_next = div_a_step[NW-1:0];
          ld_off_next = div_r_step[NW-1:0];
          state_next  = S_IDLE;
        end
      end

      S_LOAD_UPD: begin
        idx_waddr = idx_q;
        idx_wdata = {key_q, rd_start};
        idx_we    = ($signed(key_q) > $signed(rd_max));
        state_next = S_IDLE;
      end

      S_SRCH_CHK: begin
        if (lo_le_hi) begin
          idx_raddr  = IW'(mid);
          idx_q_next = IW'(mid);
          state_next = S_SRCH_CMP;
        end else if (srch_lo < bf) begin
          idx_raddr  = IW'(srch_lo);
          state_next = S_FETCH;
        end else begin
          // Key is above every block maximum, or the index is empty.
          done_next     = 1'b1;
          found_next    = 1'b0;
          position_next = '0;
          state_next    = S_IDLE;
        end
      end

      S_SRCH_CMP: begin
        if ($signed(key_q) <= $signed(rd_max)) begin
          srch_hi_next = {1'b0, BW'(idx_q)} - (BW+1)'(1);
        end else begin
          srch_lo_next = BW'(idx_q) + BW'(1);
        end
        state_next = S_SRCH_CHK;
      end

      S_FETCH: begin
        scan_addr_next = NW'(rd_start);
        scan_end_next  = end_b;
        chk_v_next     = 1'b0;
        state_next     = S_SCAN;
      end

      S_SCAN: begin
        // Reads are issued one per cycle; each compare comes in the cycle after its read.
        if (chk_v && (key_rdata == key_q)) begin
          done_next     = 1'b1;
          found_next    = 1'b1;
          position_next = chk_addr;
          chk_v_next    = 1'b0;
          state_next    = S_IDLE;
        end else if (scan_addr < scan_end) begin
          key_raddr      = scan_addr[AW-1:0];
          chk_addr_next  = scan_addr[AW-1:0];
          chk_v_next     = 1'b1;
          scan_addr_next = scan_addr + NW'(1);
        end else begin
          done_next     = 1'b1;
          found_next    = 1'b0;
          position_next = '0;
          chk_v_next    = 1'b0;
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
